@@ rtl/kdnn_pkg.sv @@
// Package for the 2-D kd-tree nearest-neighbor block: opcodes, widths and the
// command/status structs shared by the controller and the datapath. No dependencies.
`default_nettype none
package kdnn_pkg;
	localparam int unsigned CoordW = 16;
	localparam int unsigned DistW  = 34;
	localparam logic [DistW-1:0] DistOnes = {DistW{1'b1}};

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	// Controller to datapath.
	typedef struct packed {
		logic latch_item;   // capture the point and reset the walk
		logic read_node;    // issue a read of the current node
		logic eval_node;    // compare and distance on the read data
		logic ins_step;     // insert: follow or hang the new leaf
		logic ins_root;     // insert into an empty tree
		logic pop;          // query: read the top of the stack
		logic clear;        // empty the tree
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic ins_done;     // the leaf was hung in this step
		logic stack_empty;
		logic skip;         // popped far-side entry is pruned
	} stat_t;
endpackage
`default_nettype wire

@@ rtl/kdnn_if.sv @@
// Valid/ready channel interface carrying a payload of a given type.
// Depends on nothing.
`default_nettype none
interface kdnn_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/kdnn_datapath.sv @@
// Datapath: node store, search stack, distance arithmetic and best tracking.
// Depends on kdnn_pkg.
`default_nettype none
module kdnn_datapath #(
	parameter int unsigned CAPACITY = 1024
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire kdnn_pkg::cmd_t         cmd,
	input  wire logic [1:0]             in_op,
	input  wire logic signed [15:0]     in_x,
	input  wire logic signed [15:0]     in_y,
	output kdnn_pkg::stat_t             stat,
	output logic [kdnn_pkg::DistW-1:0]  best
);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned SD = CAPACITY + 2;
	localparam int unsigned SW = $clog2(SD + 1);
	localparam int unsigned GW = 32;
	localparam int unsigned DistW_l = kdnn_pkg::DistW;

	typedef struct packed {
		logic [AW-1:0] node;
		logic          level;
		logic [GW-1:0] gap;
		logic          far_side;
	} entry_t;

	// Node memory: x and y of each stored node.
	logic [2*16-1:0] node_mem [CAPACITY];
	// Child stores: a presence bit above the child index, written at the parent.
	logic [AW:0]     lk_l [CAPACITY];
	logic [AW:0]     lk_r [CAPACITY];
	entry_t          stack_mem [SD];

	logic signed [15:0] qx_q, qy_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      at_q;
	logic               level_q;
	logic               qmode_q;
	logic [SW-1:0]      sp_q;
	logic [2*16-1:0]    rd_q;
	logic [AW:0]        lk_rd_l, lk_rd_r;
	entry_t             top_q;

	logic [AW-1:0]      rd_addr;
	logic signed [15:0] nx, ny, qc, nc;
	logic signed [16:0] dx, dy, dc;
	logic [15:0]        ax, ay, ac;
	logic [GW-1:0]      sqx_s1, sqy_s1, gap_s1;
	logic               go_right_s1, lpres, rpres, hang;
	logic [DistW_l-1:0] dsum;
	logic               push_far, push_near;
	logic [SW-1:0]      sp_n1;

	// A query reads the node named by the popped stack entry; an insert walks at_q.
	assign rd_addr = qmode_q ? top_q.node : at_q;
	assign {nx, ny} = rd_q;
	assign qc = level_q ? qy_q : qx_q;
	assign nc = level_q ? ny : nx;
	assign dx = 17'(qx_q) - 17'(nx);
	assign dy = 17'(qy_q) - 17'(ny);
	assign dc = 17'(qc) - 17'(nc);
	assign ax = dx[16] ? 16'(-dx) : dx[15:0];
	assign ay = dy[16] ? 16'(-dy) : dy[15:0];
	assign ac = dc[16] ? 16'(-dc) : dc[15:0];
	assign lpres = lk_rd_l[AW];
	assign rpres = lk_rd_r[AW];
	assign dsum = DistW_l'(sqx_s1) + DistW_l'(sqy_s1);
	assign hang = cmd.ins_step && stat.ins_done;

	assign stat.empty       = (count_q == '0);
	assign stat.full        = (count_q >= CW'(CAPACITY));
	assign stat.ins_done    = (qc < nc) ? !lpres : !rpres;
	assign stat.stack_empty = (sp_q == '0);
	assign stat.skip        = top_q.far_side && !(DistW_l'(top_q.gap) < best);

	// Registered memory read of the current node, squaring stage, stack pop and node write.
	always_ff @(posedge clk) begin
		if (cmd.read_node) begin
			rd_q    <= node_mem[rd_addr];
			lk_rd_l <= lk_l[rd_addr];
			lk_rd_r <= lk_r[rd_addr];
		end
		sqx_s1 <= GW'(ax) * GW'(ax);
		sqy_s1 <= GW'(ay) * GW'(ay);
		gap_s1 <= GW'(ac) * GW'(ac);
		go_right_s1 <= qc > nc;
		if (cmd.pop) begin
			top_q <= stack_mem[SW'(sp_q - 1'b1)];
		end
		if (cmd.ins_root || hang) begin
			node_mem[count_q[AW-1:0]] <= {qx_q, qy_q};
		end
	end

	// The slot of the node about to be appended loses its children when an insert
	// is taken; the parent gains its new child when the leaf is hung.
	always_ff @(posedge clk) begin
		if (cmd.latch_item && (in_op == kdnn_pkg::OP_INSERT) && !stat.full) begin
			lk_l[count_q[AW-1:0]] <= '0;
			lk_r[count_q[AW-1:0]] <= '0;
		end else if (hang) begin
			if (qc < nc) lk_l[at_q] <= {1'b1, count_q[AW-1:0]};
			else         lk_r[at_q] <= {1'b1, count_q[AW-1:0]};
		end
	end

	// Stack pushes happen in the evaluation cycle, far side then near side.
	assign push_far  = cmd.eval_node && (go_right_s1 ? lpres : rpres) && (sp_q < SW'(SD));
	assign sp_n1     = push_far ? SW'(sp_q + 1'b1) : sp_q;
	assign push_near = cmd.eval_node && (go_right_s1 ? rpres : lpres) && (sp_n1 < SW'(SD));

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			stack_mem[0] <= '{node: '0, level: 1'b0, gap: '0, far_side: 1'b0};
		end else begin
			if (push_far) begin
				stack_mem[sp_q] <= '{node: go_right_s1 ? lk_rd_l[AW-1:0] : lk_rd_r[AW-1:0],
					level: ~level_q, gap: gap_s1, far_side: 1'b1};
			end
			if (push_near) begin
				stack_mem[sp_n1] <= '{node: go_right_s1 ? lk_rd_r[AW-1:0] : lk_rd_l[AW-1:0],
					level: ~level_q, gap: '0, far_side: 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sp_q    <= '0;
			best    <= kdnn_pkg::DistOnes;
			at_q    <= '0;
			level_q <= 1'b0;
			qmode_q <= 1'b0;
			qx_q    <= '0;
			qy_q    <= '0;
		end else begin
			if (cmd.latch_item) begin
				qx_q    <= in_x;
				qy_q    <= in_y;
				at_q    <= '0;
				level_q <= 1'b0;
				qmode_q <= (in_op == kdnn_pkg::OP_QUERY);
				best    <= kdnn_pkg::DistOnes;
				sp_q    <= (in_op == kdnn_pkg::OP_QUERY) ? SW'(1) : '0;
			end
			if (cmd.clear) count_q <= '0;
			if (cmd.ins_root) begin
				count_q <= CW'(1);
			end
			if (cmd.ins_step) begin
				if (stat.ins_done) begin
					count_q <= CW'(count_q + 1'b1);
				end else begin
					at_q    <= (qc < nc) ? lk_rd_l[AW-1:0] : lk_rd_r[AW-1:0];
					level_q <= ~level_q;
				end
			end
			// A visited node takes its index and level from the popped entry.
			if (cmd.read_node && qmode_q) begin
				at_q    <= top_q.node;
				level_q <= top_q.level;
			end
			if (cmd.pop) begin
				sp_q <= SW'(sp_q - 1'b1);
			end
			if (cmd.eval_node) begin
				if (dsum < best) best <= dsum;
				sp_q <= SW'(sp_n1 + SW'(push_near));
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/kdnn_ctrl.sv @@
// Controller state machine sequencing clear, insert and query operations.
// Depends on kdnn_pkg.
`default_nettype none
module kdnn_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire logic [1:0]      in_op,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic                 out_status,
	output logic                 out_use_best,
	input  wire kdnn_pkg::stat_t stat,
	output kdnn_pkg::cmd_t       cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_INS_RD, S_INS_EV, S_POP, S_Q_RD, S_Q_SQ, S_Q_EV
	} state_t;
	state_t state_q;
	logic   take;
	logic   fin;

	assign in_ready = (state_q == S_IDLE) && !(out_valid && !out_ready);
	assign take     = in_valid && in_ready;

	// fin marks the cycle in which the current item's result is complete.
	always_comb begin
		cmd = '0;
		fin = 1'b0;
		cmd.latch_item = take;
		cmd.clear      = take && (in_op == kdnn_pkg::OP_CLEAR);
		unique case (state_q)
			S_IDLE:   fin = take && (in_op != kdnn_pkg::OP_INSERT) &&
				(in_op != kdnn_pkg::OP_QUERY);
			S_INS_RD: begin
				if (stat.empty) cmd.ins_root = 1'b1;
				else            cmd.read_node = 1'b1;
				fin = stat.full || stat.empty;
			end
			S_INS_EV: begin
				cmd.ins_step = 1'b1;
				fin = stat.ins_done;
			end
			S_POP:    begin
				if (!stat.stack_empty) cmd.pop = 1'b1;
				fin = stat.empty || stat.stack_empty;
			end
			S_Q_RD:   cmd.read_node = !stat.skip;
			S_Q_SQ:   ;
			S_Q_EV:   cmd.eval_node = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid    <= 1'b0;
			out_status   <= 1'b0;
			out_use_best <= 1'b0;
		end else begin
			if (fin) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (take) begin
					out_status   <= 1'b0;
					out_use_best <= 1'b0;
					unique case (in_op)
						kdnn_pkg::OP_INSERT: state_q <= S_INS_RD;
						kdnn_pkg::OP_QUERY:  state_q <= S_POP;
						default:             ;
					endcase
				end
				S_INS_RD: begin
					if (stat.full) begin
						out_status <= 1'b1;
						state_q    <= S_IDLE;
					end else if (stat.empty) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_INS_EV;
					end
				end
				S_INS_EV: begin
					if (stat.ins_done) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_INS_RD;
					end
				end
				S_POP: begin
					if (stat.empty || stat.stack_empty) begin
						out_use_best <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_Q_RD;
					end
				end
				S_Q_RD: state_q <= stat.skip ? S_POP : S_Q_SQ;
				S_Q_SQ: state_q <= S_Q_EV;
				S_Q_EV: state_q <= S_POP;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/kd_tree_nearest_neighbor_2d.sv @@
// Top level of the 2-D kd-tree nearest-neighbor block.
// Depends on kdnn_pkg, kdnn_if, kdnn_ctrl and kdnn_datapath.
`default_nettype none
// Each input item is a clear, an insert, a nearest-neighbor query or a no-op,
// and each gives exactly one result item. Insert walks down the tree one level
// at a time, a node read and then a compare per level. A query visits a node
// by pop, node read, squaring and evaluation, and drops a pruned far-side
// entry after the pop and the skip check. The block handles one item
// at a time; a result that waits on a stalled output holds off the next item
// until it is taken. The node store needs no clearing pass: a node is only
// reachable after it was written. An empty tree answers a query with all ones.
module kd_tree_nearest_neighbor_2d #(
	parameter int unsigned CAPACITY = 1024
) (
	input wire clk,
	input wire arst_n,
	kdnn_if.sink   in_ch,
	kdnn_if.source out_ch
);
	kdnn_pkg::cmd_t  cmd;
	kdnn_pkg::stat_t stat;
	logic [kdnn_pkg::DistW-1:0] best;
	logic status, use_best;

	kdnn_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.data.opcode),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_status(status), .out_use_best(use_best), .stat, .cmd
	);

	kdnn_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk, .arst_n, .cmd, .in_op(in_ch.data.opcode),
		.in_x(in_ch.data.point_x), .in_y(in_ch.data.point_y), .stat, .best
	);

	assign out_ch.data.status        = status;
	assign out_ch.data.best_distance = use_best ? best : '0;
endmodule
`default_nettype wire

@@ rtl/kdnn_checker.sv @@
// Port-level checker for the kd-tree block, bound to the top level.
// Depends on kd_tree_nearest_neighbor_2d and kdnn_if.
`default_nettype none
module kdnn_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire out_status,
	input wire [33:0] out_best
);
	// A taken item must be followed by in_ready low or by a result leaving.
	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!in_ready || (out_valid && out_ready)))
		else $error("item taken while busy");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_best)) else $error("result changed");
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_status) |-> (out_best == 34'd0)) else $error("full with dist");
endmodule
bind kd_tree_nearest_neighbor_2d kdnn_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_status(out_ch.data.status), .out_best(out_ch.data.best_distance)
);
`default_nettype wire
